### rtl/rau_pkg.sv
package rau_pkg;

    localparam int unsigned DefWidth = 32;
    localparam int unsigned WideW    = 64;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_LT  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_COMBINE,
        S_GCD_STRIP,
        S_GCD_SUB,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_NEXT,
        S_CHECK,
        S_OUT
    } t_state;

endpackage

### rtl/rational_arith_unit_core.sv
// Exact fraction arithmetic unit. Each input word carries an opcode (add,
// subtract, multiply, divide, equal, less-than) and two fractions
// num/den with 32-bit signed numerators and 31-bit denominators. Arithmetic
// results come back reduced to lowest terms, sign in the numerator; a zero
// denominator, zero divisor or unknown opcode reports status 1, and a
// reduced result that does not fit WIDTH bits reports status 2 with all
// other fields zero. Compares return only truth. One word is processed at a
// time: up to three products are formed on one shared 33x33 multiplier, one
// per cycle, the gcd is found by a binary subtract-and-shift loop, then
// numerator and denominator are divided by it on one shared restoring
// divider, one quotient bit a cycle. i_stall holds a finished result; a new
// word is taken only in the cycle after the result has been handed off.
module rational_arith_unit_core #(
    parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic signed [31:0] i_a_num,
    input  logic [30:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic [30:0] i_b_den,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic        o_truth,
    output logic [1:0]  o_status
);

    localparam int unsigned W = rau_pkg::WideW;
    localparam logic [W-1:0] Lim = (W'(1) << (WIDTH - 1)) - W'(1);

    rau_pkg::t_state r_state, n_state;

    // captured operands
    logic [2:0]         r_op;
    logic signed [31:0] r_an, r_bn;
    logic [30:0]        r_ad, r_bd;
    // products and working values
    logic signed [W-1:0] r_p1, r_p2;
    logic [W-1:0] r_mag, r_den;
    logic         r_neg;
    logic [W-1:0] r_gx, r_gy;      // gcd working pair
    logic [6:0]   r_gk;            // common power of two
    logic [W-1:0] r_g;
    logic [W-1:0] r_q, r_rem;
    logic [6:0]   r_cnt;
    logic         r_second;        // dividing denominator
    logic [W-1:0] r_qmag;

    // output register
    logic               r_ovld;
    logic signed [31:0] r_onum;
    logic [30:0]        r_oden;
    logic               r_otruth;
    logic [1:0]         r_ostat;

    // shared multiplier operands
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    always_comb begin
        if (r_state == rau_pkg::S_MUL1) begin
            w_ma = 33'(r_an);
            w_mb = (r_op == rau_pkg::OP_MUL) ? 33'(r_bn) : $signed({2'b0, r_bd});
        end else if (r_state == rau_pkg::S_COMBINE) begin
            // third pass: ad*bd, the denominator for add/sub
            w_ma = $signed({2'b0, r_ad});
            w_mb = $signed({2'b0, r_bd});
        end else begin
            // second pass: b*ad for add/sub/compare, ad*bd or ad*bn otherwise
            w_ma = $signed({2'b0, r_ad});
            w_mb = (r_op == rau_pkg::OP_DIV) ? 33'(r_bn) : $signed({2'b0, r_bd});
            if (r_op == rau_pkg::OP_ADD || r_op == rau_pkg::OP_SUB ||
                r_op == rau_pkg::OP_EQ || r_op == rau_pkg::OP_LT) begin
                w_ma = 33'(r_bn);
                w_mb = $signed({2'b0, r_ad});
            end
        end
        w_prod = w_ma * w_mb;
    end

    // shared subtractor for divide step
    logic [W:0]   w_trial;
    logic [W-1:0] w_rem_sh;
    logic [W-1:0] w_dividend;
    assign w_dividend = r_second ? r_den : r_mag;
    assign w_rem_sh   = {r_rem[W-2:0], r_q[W-1]};
    assign w_trial    = {1'b0, w_rem_sh} - {1'b0, r_g};

    logic w_bad;
    assign w_bad = (i_op > rau_pkg::OP_LT) || (i_a_den == 31'd0) || (i_b_den == 31'd0) ||
                   (i_op == 3'(rau_pkg::OP_DIV) && i_b_num == 32'sd0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            rau_pkg::S_IDLE:      if (i_valid && !r_ovld && !w_bad) n_state = rau_pkg::S_MUL1;
            rau_pkg::S_MUL1:      n_state = rau_pkg::S_MUL2;
            rau_pkg::S_MUL2:      n_state = rau_pkg::S_COMBINE;
            rau_pkg::S_COMBINE:   n_state = (r_op == rau_pkg::OP_EQ || r_op == rau_pkg::OP_LT)
                                            ? rau_pkg::S_OUT : rau_pkg::S_GCD_STRIP;
            rau_pkg::S_GCD_STRIP: if (r_gx == '0) n_state = rau_pkg::S_DIV_INIT;
                                  else if (r_gx[0] && r_gy[0]) n_state = rau_pkg::S_GCD_SUB;
            rau_pkg::S_GCD_SUB:   if (r_gx == r_gy || r_gy == '0) n_state = rau_pkg::S_DIV_INIT;
            rau_pkg::S_DIV_INIT:  n_state = rau_pkg::S_DIV_STEP;
            rau_pkg::S_DIV_STEP:  if (r_cnt == 7'd0) n_state = rau_pkg::S_DIV_NEXT;
            rau_pkg::S_DIV_NEXT:  n_state = r_second ? rau_pkg::S_CHECK : rau_pkg::S_DIV_INIT;
            rau_pkg::S_CHECK:     n_state = rau_pkg::S_OUT;
            rau_pkg::S_OUT:       n_state = rau_pkg::S_IDLE;
            default:              n_state = rau_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovld) begin
                if (!i_stall) r_ovld <= 1'b0;
            end else if (r_state == rau_pkg::S_OUT ||
                         (r_state == rau_pkg::S_IDLE && i_valid && w_bad)) begin
                r_ovld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rau_pkg::S_IDLE: begin
                // result word is held untouched until it is taken
                if (!r_ovld) begin
                    r_op <= i_op; r_an <= i_a_num; r_bn <= i_b_num;
                    r_ad <= i_a_den; r_bd <= i_b_den;
                    r_onum <= '0; r_oden <= '0; r_otruth <= 1'b0;
                    r_ostat <= rau_pkg::ST_INVALID;
                end
            end
            rau_pkg::S_MUL1: r_p1 <= W'(w_prod);
            rau_pkg::S_MUL2: r_p2 <= W'(w_prod);
            rau_pkg::S_COMBINE: begin : comb_blk
                logic signed [W-1:0] n, d;
                n = r_p1;
                d = r_p2;
                case (r_op)
                    rau_pkg::OP_ADD: begin
                        n = r_p1 + r_p2;
                        d = W'(w_prod);
                    end
                    rau_pkg::OP_SUB: begin
                        n = r_p1 - r_p2;
                        d = W'(w_prod);
                    end
                    rau_pkg::OP_DIV: if (r_p2 < 0) begin
                        n = -r_p1; d = -r_p2;
                    end
                    default: ;
                endcase
                if (r_op == rau_pkg::OP_EQ) r_otruth <= (r_p1 == r_p2);
                else if (r_op == rau_pkg::OP_LT) r_otruth <= (r_p1 < r_p2);
                r_ostat  <= rau_pkg::ST_OK;
                r_neg <= n[W-1];
                r_mag <= n[W-1] ? W'(-n) : W'(n);
                r_den <= W'(d);
                r_gx  <= n[W-1] ? W'(-n) : W'(n);
                r_gy  <= W'(d);
                r_gk  <= '0;
            end
            rau_pkg::S_GCD_STRIP: begin
                if (r_gx == '0) r_g <= r_gy;
                else if (!r_gx[0] && !r_gy[0]) begin
                    r_gx <= r_gx >> 1; r_gy <= r_gy >> 1; r_gk <= r_gk + 7'd1;
                end else if (!r_gx[0]) r_gx <= r_gx >> 1;
                else if (!r_gy[0]) r_gy <= r_gy >> 1;
            end
            rau_pkg::S_GCD_SUB: begin
                // both odd: subtract, then strip twos from the difference
                if (r_gx == r_gy || r_gy == '0) r_g <= (r_gy == '0 ? r_gx : r_gx) << r_gk;
                else if (!r_gy[0]) r_gy <= r_gy >> 1;
                else if (!r_gx[0]) r_gx <= r_gx >> 1;
                else if (r_gx > r_gy) r_gx <= r_gx - r_gy;
                else r_gy <= r_gy - r_gx;
            end
            rau_pkg::S_DIV_INIT: begin
                r_q <= w_dividend; r_rem <= '0; r_cnt <= 7'(W - 1);
            end
            rau_pkg::S_DIV_STEP: begin
                r_cnt <= r_cnt - 7'd1;
                if (!w_trial[W]) begin
                    r_rem <= w_trial[W-1:0]; r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh; r_q <= {r_q[W-2:0], 1'b0};
                end
            end
            rau_pkg::S_DIV_NEXT: begin
                if (r_second) r_den <= r_q;
                else r_qmag <= r_q;
            end
            rau_pkg::S_CHECK: begin
                if (r_den > Lim || (r_neg ? r_qmag > Lim + W'(1) : r_qmag > Lim)) begin
                    r_ostat <= rau_pkg::ST_OVERFLOW;
                end else begin
                    r_onum <= r_neg ? 32'(-r_qmag) : 32'(r_qmag);
                    r_oden <= 31'(r_den);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_second <= 1'b0;
        else if (r_state == rau_pkg::S_COMBINE) r_second <= 1'b0;
        else if (r_state == rau_pkg::S_DIV_NEXT) r_second <= 1'b1;
    end

    assign o_stall   = (r_state != rau_pkg::S_IDLE) || r_ovld;
    assign o_valid   = r_ovld;
    assign o_res_num = r_onum;
    assign o_res_den = r_oden;
    assign o_truth   = r_otruth;
    assign o_status  = r_ostat;

endmodule

### rtl/rau_checker.sv
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_truth,
    input logic [1:0]  o_status,
    input logic [30:0] o_res_den
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res_den))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3)
        else $error("bad status");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != rau_pkg::ST_OK |-> !o_truth && o_res_den == 31'd0)
        else $error("error result not cleared");
endmodule

bind rational_arith_unit_core rau_checker u_chk (.*);

### test/rational_arith_unit_checker.sv
module rational_arith_unit_checker #(
    parameter int unsigned WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_a_num,
    input  logic [30:0]        i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic [30:0]        i_b_den,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_res_num,
    input  logic [30:0]        o_res_den,
    input  logic               o_truth,
    input  logic [1:0]         o_status,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_words_in,
    output int                 o_words_out
);

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               truth;
        logic [1:0]         status;
    } t_fraction_res;

    t_fraction_res exp_fractions[$];

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_fraction_res fraction_result(input logic [2:0] op,
            input logic signed [31:0] an, input logic [30:0] ad_u,
            input logic signed [31:0] bn, input logic [30:0] bd_u);
        t_fraction_res r;
        logic signed [63:0] ad, bd, n, d, lhs, rhs;
        logic [63:0] mag, dd, g, lim;
        logic neg;
        r = '0;
        ad = {33'd0, ad_u};
        bd = {33'd0, bd_u};
        if (op > rau_pkg::OP_LT || ad == 0 || bd == 0 ||
            (op == rau_pkg::OP_DIV && bn == 0)) begin
            r.status = rau_pkg::ST_INVALID;
            return r;
        end
        lhs = 64'(an) * bd;
        rhs = 64'(bn) * ad;
        n = 0;
        d = ad * bd;
        case (op)
            rau_pkg::OP_ADD: n = lhs + rhs;
            rau_pkg::OP_SUB: n = lhs - rhs;
            rau_pkg::OP_MUL: n = 64'(an) * 64'(bn);
            rau_pkg::OP_DIV: begin
                n = lhs;
                d = ad * 64'(bn);
                if (d < 0) begin
                    d = -d;
                    n = -n;
                end
            end
            rau_pkg::OP_EQ: begin
                r.truth = (lhs == rhs);
                return r;
            end
            default: begin
                r.truth = (lhs < rhs);
                return r;
            end
        endcase
        neg = n < 0;
        mag = neg ? -n : n;
        dd = d;
        g = gcd64(mag, dd);
        mag = mag / g;
        dd = dd / g;
        lim = (64'd1 << (WIDTH - 1)) - 1;
        if (dd > lim || (neg ? mag > lim + 1 : mag > lim)) begin
            r.status = rau_pkg::ST_OVERFLOW;
            return r;
        end
        r.num = neg ? -mag[31:0] : mag[31:0];
        r.den = dd[30:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fraction_res want, got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_words_in   <= 0;
            o_words_out  <= 0;
            o_pending    <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                exp_fractions.push_back(fraction_result(i_op, i_a_num, i_a_den,
                                                        i_b_num, i_b_den));
                o_words_in <= o_words_in + 1;
            end
            if (o_valid && !i_stall) begin
                got = '{o_res_num, o_res_den, o_truth, o_status};
                o_words_out <= o_words_out + 1;
                if (exp_fractions.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word num=%0d den=%0d t=%0d st=%0d",
                                 o_res_num, o_res_den, o_truth, o_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = exp_fractions.pop_front();
                    if (want != got) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp %0d/%0d t=%0d st=%0d, got %0d/%0d t=%0d st=%0d",
                                     want.num, want.den, want.truth, want.status,
                                     got.num, got.den, got.truth, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= exp_fractions.size();
        end
    end
endmodule

### test/rational_arith_unit_core_tb.sv
module rational_arith_unit_core_tb;

    localparam int NumRandom = 1300;
    // worst case word plus the longest receiver stall, taken several times
    localparam int IdleLimit = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_op;
    logic signed [31:0] i_a_num;
    logic [30:0]        i_a_den;
    logic signed [31:0] i_b_num;
    logic [30:0]        i_b_den;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_res_num;
    logic [30:0]        o_res_den;
    logic               o_truth;
    logic [1:0]         o_status;

    int fail_count, pending, words_in, words_out;
    int idle_cycles;
    bit quiet_phase;   // no idling on either side near the end
    int stall_left;

    rational_arith_unit_core i_dut (.*);

    rational_arith_unit_checker i_chk (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op, .i_a_num, .i_a_den,
        .i_b_num, .i_b_den, .o_valid, .i_stall, .o_res_num, .o_res_den,
        .o_truth, .o_status, .o_fail_count(fail_count), .o_pending(pending),
        .o_words_in(words_in), .o_words_out(words_out)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stall bursts, off in the quiet phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= (stall_left > 1);
        end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 15);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: cycles with no word moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog: no progress for %0d cycles", IdleLimit);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Present one word and hold it until accepted; valid stays up for a
    // following word unless an idle gap is drawn.
    task automatic send_word(input logic [2:0] op, input logic signed [31:0] an,
                             input logic [30:0] ad, input logic signed [31:0] bn,
                             input logic [30:0] bd);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_a_num <= an;
        i_a_den <= ad;
        i_b_num <= bn;
        i_b_den <= bd;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Operand mix: mostly small values so results reduce and fit, some wide.
    function automatic logic signed [31:0] pick_num();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(0, 9))
            0:       return 31'd0;
            1:       return 31'($urandom);
            2:       return 31'h7fffffff;
            default: return 31'($urandom_range(1, 60));
        endcase
    endfunction

    initial begin
        logic [2:0] op;
        logic signed [31:0] an, bn;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = '0;
        i_a_num = '0;
        i_a_den = '0;
        i_b_num = '0;
        i_b_den = '0;
        quiet_phase = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each op, zero results, zero denominators, divide by zero,
        // unknown codes, extremes and overflow.
        send_word(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_word(rau_pkg::OP_SUB, 1, 2, 1, 2);
        send_word(rau_pkg::OP_MUL, -4, 6, 3, 8);
        send_word(rau_pkg::OP_DIV, 3, 4, -9, 8);
        send_word(rau_pkg::OP_EQ, 2, 4, 1, 2);
        send_word(rau_pkg::OP_LT, -1, 3, 1, 3);
        send_word(rau_pkg::OP_LT, 1, 3, -1, 3);
        send_word(rau_pkg::OP_ADD, 1, 0, 1, 1);
        send_word(rau_pkg::OP_EQ, 1, 1, 1, 0);
        send_word(rau_pkg::OP_DIV, 5, 7, 0, 3);
        send_word(3'd6, 1, 1, 1, 1);
        send_word(3'd7, 1, 1, 1, 1);
        send_word(rau_pkg::OP_MUL, 32'sh80000000, 1, 32'sh80000000, 1);
        send_word(rau_pkg::OP_MUL, 32'sh80000000, 1, 1, 1);
        send_word(rau_pkg::OP_DIV, 32'sh80000000, 1, -1, 1);
        send_word(rau_pkg::OP_ADD, 32'sh7fffffff, 1, 32'sh7fffffff, 1);
        send_word(rau_pkg::OP_SUB, 32'sh80000000, 1, 1, 1);
        send_word(rau_pkg::OP_MUL, 1, 31'h7fffffff, 1, 31'h7fffffff);
        send_word(rau_pkg::OP_ADD, 1, 31'h7fffffff, 1, 31'h7ffffffe);
        send_word(rau_pkg::OP_DIV, 32'sh7fffffff, 31'h7fffffff, 32'sh80000000,
                  31'h7fffffff);
        send_word(rau_pkg::OP_EQ, 32'sh80000000, 31'h7fffffff, 32'sh80000000,
                  31'h7fffffff);
        send_word(rau_pkg::OP_LT, 0, 5, 0, 9);
        send_word(rau_pkg::OP_MUL, 0, 9, -7, 3);

        // Hold off until every pending result has drained.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int k = 0; k < NumRandom; k++) begin
            if (k == NumRandom - 150)
                quiet_phase = 1'b1;
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
            an = pick_num();
            bn = pick_num();
            send_word(op, an, pick_den(), bn, pick_den());
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("covered %0d words sent, %0d results checked: all six ops,", words_in,
                 words_out);
        $display("invalid and unknown codes, overflow, and random stalls on both sides");
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

### sim.f
rtl/rau_pkg.sv
rtl/rational_arith_unit_core.sv
rtl/rau_checker.sv
test/rational_arith_unit_checker.sv
test/rational_arith_unit_core_tb.sv
